// ----- design/rhc_pkg.sv -----
// ----------------------------------------------------------------------------
// rhc_pkg: shared types for the RGB to HSV converter
// Pixel and result item layouts, hue sector codes and the side data that
// travels down the divider chain with each item.
// ----------------------------------------------------------------------------
package rhc_pkg;

	localparam int CHAN_W = 8;
	localparam int HUE_W  = 15;

	typedef struct packed {
		logic [CHAN_W-1:0] red_in;
		logic [CHAN_W-1:0] green_in;
		logic [CHAN_W-1:0] blue_in;
	} rhc_in_t;

	typedef struct packed {
		logic [HUE_W-1:0]  hue_out;
		logic [CHAN_W-1:0] sat_out;
		logic [CHAN_W-1:0] val_out;
	} rhc_out_t;

	typedef enum logic [1:0] {
		SECT_RED   = 2'd0,
		SECT_GREEN = 2'd1,
		SECT_BLUE  = 2'd2
	} sector_t;

	typedef struct packed {
		sector_t           sector;
		logic              neg;
		logic              gray;
		logic [CHAN_W-1:0] val;
		logic [CHAN_W-1:0] delta;
	} rhc_side_t;

endpackage

// ----- design/rhc_prep.sv -----
// ----------------------------------------------------------------------------
// rhc_prep: front end of the converter
// Finds the largest and smallest channel, picks the hue sector and forms the
// two dividends (hue and saturation) over two registered stages.
// ----------------------------------------------------------------------------
module rhc_prep #(
	parameter int HUE_FRAC_BITS = 6,
	parameter int NW            = 22
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              up_valid,
	output logic              up_ready,
	input  rhc_pkg::rhc_in_t  up_pix,
	output logic              dn_valid,
	input  logic              dn_ready,
	output logic [NW-1:0]     dn_rem_h,
	output logic [NW-1:0]     dn_rem_s,
	output rhc_pkg::rhc_side_t dn_side
);
	import rhc_pkg::*;

	localparam logic [NW-1:0] SIXTY_K = NW'(60 << HUE_FRAC_BITS);

	logic            valid_s1;
	logic            valid_s2;
	logic            ready_s1;
	rhc_side_t       side_s1;
	logic [CHAN_W:0] diff_s1;
	rhc_side_t       side_s2;
	logic [NW-1:0]   rem_h_s2;
	logic [NW-1:0]   rem_s_s2;

	rhc_side_t       side_c;
	logic [CHAN_W:0] diff_c;
	logic [CHAN_W-1:0] hi_c;
	logic [CHAN_W-1:0] lo_c;
	logic [CHAN_W:0]   mag_full_c;
	logic [CHAN_W-1:0] mag_c;
	logic [NW-1:0]     delta_ext_c;

	assign ready_s1 = !valid_s2 || dn_ready;
	assign up_ready = !valid_s1 || ready_s1;

	always_comb begin
		hi_c = up_pix.red_in;
		lo_c = up_pix.red_in;
		if (up_pix.green_in > hi_c) hi_c = up_pix.green_in;
		if (up_pix.blue_in > hi_c) hi_c = up_pix.blue_in;
		if (up_pix.green_in < lo_c) lo_c = up_pix.green_in;
		if (up_pix.blue_in < lo_c) lo_c = up_pix.blue_in;
		side_c        = '0;
		side_c.val    = hi_c;
		side_c.delta  = hi_c - lo_c;
		side_c.gray   = (hi_c == lo_c);
		priority if (hi_c == up_pix.red_in) begin
			side_c.sector = SECT_RED;
			diff_c = {1'b0, up_pix.green_in} - {1'b0, up_pix.blue_in};
		end else if (hi_c == up_pix.green_in) begin
			side_c.sector = SECT_GREEN;
			diff_c = {1'b0, up_pix.blue_in} - {1'b0, up_pix.red_in};
		end else begin
			side_c.sector = SECT_BLUE;
			diff_c = {1'b0, up_pix.red_in} - {1'b0, up_pix.green_in};
		end
		side_c.neg    = diff_c[CHAN_W];
	end

	always_comb begin
		mag_full_c  = diff_s1[CHAN_W] ? (~diff_s1 + 1'b1) : diff_s1;
		mag_c       = mag_full_c[CHAN_W-1:0];
		delta_ext_c = {{(NW-CHAN_W){1'b0}}, side_s1.delta};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (up_ready) valid_s1 <= up_valid;
			if (ready_s1) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			side_s1 <= side_c;
			diff_s1 <= diff_c;
		end
		if (ready_s1 && valid_s1) begin
			side_s2     <= side_s1;
			rem_h_s2    <= SIXTY_K * {{(NW-CHAN_W){1'b0}}, mag_c};
			rem_s_s2    <= (delta_ext_c << CHAN_W) - delta_ext_c;
		end
	end

	assign dn_valid = valid_s2;
	assign dn_rem_h = rem_h_s2;
	assign dn_rem_s = rem_s_s2;
	assign dn_side  = side_s2;

endmodule

// ----- design/rhc_div_cell.sv -----
// ----------------------------------------------------------------------------
// rhc_div_cell: one restoring division step for both lanes
// Settles one quotient bit of the hue and of the saturation quotient and
// hands remainders, quotients and side data to the next cell.
// ----------------------------------------------------------------------------
module rhc_div_cell #(
	parameter int NW    = 22,
	parameter int NSTEP = 14,
	parameter int IDX   = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               up_valid,
	output logic               up_ready,
	input  logic [NW-1:0]      up_rem_h,
	input  logic [NW-1:0]      up_rem_s,
	input  logic [NSTEP-1:0]   up_q_h,
	input  logic [NSTEP-1:0]   up_q_s,
	input  rhc_pkg::rhc_side_t up_side,
	output logic               dn_valid,
	input  logic               dn_ready,
	output logic [NW-1:0]      dn_rem_h,
	output logic [NW-1:0]      dn_rem_s,
	output logic [NSTEP-1:0]   dn_q_h,
	output logic [NSTEP-1:0]   dn_q_s,
	output rhc_pkg::rhc_side_t dn_side
);
	import rhc_pkg::*;

	localparam int SH = NSTEP - 1 - IDX;

	logic             valid_q;
	logic [NW-1:0]    rem_h_q;
	logic [NW-1:0]    rem_s_q;
	logic [NSTEP-1:0] q_h_q;
	logic [NSTEP-1:0] q_s_q;
	rhc_side_t        side_q;

	logic [NW-1:0] dsh_h;
	logic [NW-1:0] dsh_s;
	logic          ge_h;
	logic          ge_s;

	assign dsh_h = {{(NW-CHAN_W){1'b0}}, up_side.delta} << SH;
	assign dsh_s = {{(NW-CHAN_W){1'b0}}, up_side.val} << SH;
	assign ge_h  = (up_rem_h >= dsh_h);
	assign ge_s  = (up_rem_s >= dsh_s);

	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			rem_h_q <= ge_h ? (up_rem_h - dsh_h) : up_rem_h;
			rem_s_q <= ge_s ? (up_rem_s - dsh_s) : up_rem_s;
			q_h_q   <= {up_q_h[NSTEP-2:0], ge_h};
			q_s_q   <= {up_q_s[NSTEP-2:0], ge_s};
			side_q  <= up_side;
		end
	end

	assign dn_valid = valid_q;
	assign dn_rem_h = rem_h_q;
	assign dn_rem_s = rem_s_q;
	assign dn_q_h   = q_h_q;
	assign dn_q_s   = q_s_q;
	assign dn_side  = side_q;

endmodule

// ----- design/rhc_finish.sv -----
// ----------------------------------------------------------------------------
// rhc_finish: hue assembly and output register
// Applies sign and sector offset to the hue quotient, wraps negative hue,
// clears gray pixels and holds the result item for the consumer.
// ----------------------------------------------------------------------------
module rhc_finish #(
	parameter int HUE_FRAC_BITS = 6,
	parameter int NSTEP         = 14
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               up_valid,
	output logic               up_ready,
	input  logic [NSTEP-1:0]   up_q_h,
	input  logic [NSTEP-1:0]   up_q_s,
	input  rhc_pkg::rhc_side_t up_side,
	output logic               dn_valid,
	input  logic               dn_ready,
	output rhc_pkg::rhc_out_t  dn_hsv
);
	import rhc_pkg::*;

	localparam int HCW = $clog2((360 << HUE_FRAC_BITS) + 1);
	localparam logic [HCW-1:0] DEG120 = HCW'(120 << HUE_FRAC_BITS);
	localparam logic [HCW-1:0] DEG240 = HCW'(240 << HUE_FRAC_BITS);
	localparam logic [HCW-1:0] DEG360 = HCW'(360 << HUE_FRAC_BITS);

	logic           valid_q;
	rhc_out_t       hsv_q;
	logic [HCW-1:0] qe;
	logic [HCW-1:0] hue_c;
	rhc_out_t       hsv_c;

	assign qe = HCW'(up_q_h);

	always_comb begin
		unique case (up_side.sector)
			SECT_RED:   hue_c = (up_side.neg && qe != '0) ? (DEG360 - qe) : qe;
			SECT_GREEN: hue_c = up_side.neg ? (DEG120 - qe) : (DEG120 + qe);
			SECT_BLUE:  hue_c = up_side.neg ? (DEG240 - qe) : (DEG240 + qe);
			default:    hue_c = '0;
		endcase
		hsv_c.hue_out = up_side.gray ? '0 : HUE_W'(hue_c);
		hsv_c.sat_out = up_side.gray ? '0 : up_q_s[CHAN_W-1:0];
		hsv_c.val_out = up_side.val;
	end

	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) hsv_q <= hsv_c;
	end

	assign dn_valid = valid_q;
	assign dn_hsv   = hsv_q;

endmodule

// ----- design/rgb_to_hsv_converter_unit.sv -----
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_unit: pipelined RGB to HSV pixel converter
// Two front stages, a chain of division cells (one quotient bit per cell for
// hue and saturation at once) and an output register.
//
//   channel | valid    | ready    | payload
//   pixel   | pix_valid| pix_ready| pix (red_in, green_in, blue_in)
//   result  | hsv_valid| hsv_ready| hsv (hue_out, sat_out, val_out)
//
// One item per cycle sustained while the result side keeps taking items; the
// division chain has one cell per quotient bit.
// Reset clears only the stage valid flags.
// A stalled result holds in the output register; each stage still takes an
// item while it is empty, so bubbles close up under a stall.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_unit #(
	parameter int HUE_FRAC_BITS = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pix_valid,
	output logic              pix_ready,
	input  rhc_pkg::rhc_in_t  pix,
	output logic              hsv_valid,
	input  logic              hsv_ready,
	output rhc_pkg::rhc_out_t hsv
);
	import rhc_pkg::*;

	localparam int QW    = $clog2((60 << HUE_FRAC_BITS) + 1);
	localparam int NSTEP = (QW > CHAN_W) ? QW : CHAN_W;
	localparam int NW    = NSTEP + CHAN_W;

	logic             valid_w [NSTEP+1];
	logic             ready_w [NSTEP+1];
	logic [NW-1:0]    rem_h_w [NSTEP+1];
	logic [NW-1:0]    rem_s_w [NSTEP+1];
	logic [NSTEP-1:0] q_h_w   [NSTEP+1];
	logic [NSTEP-1:0] q_s_w   [NSTEP+1];
	rhc_side_t        side_w  [NSTEP+1];

	assign q_h_w[0] = '0;
	assign q_s_w[0] = '0;

	rhc_prep #(
		.HUE_FRAC_BITS(HUE_FRAC_BITS),
		.NW           (NW)
	) u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (pix_valid),
		.up_ready (pix_ready),
		.up_pix   (pix),
		.dn_valid (valid_w[0]),
		.dn_ready (ready_w[0]),
		.dn_rem_h (rem_h_w[0]),
		.dn_rem_s (rem_s_w[0]),
		.dn_side  (side_w[0])
	);

	for (genvar i = 0; i < NSTEP; i++) begin : g_cell
		rhc_div_cell #(
			.NW   (NW),
			.NSTEP(NSTEP),
			.IDX  (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (valid_w[i]),
			.up_ready (ready_w[i]),
			.up_rem_h (rem_h_w[i]),
			.up_rem_s (rem_s_w[i]),
			.up_q_h   (q_h_w[i]),
			.up_q_s   (q_s_w[i]),
			.up_side  (side_w[i]),
			.dn_valid (valid_w[i+1]),
			.dn_ready (ready_w[i+1]),
			.dn_rem_h (rem_h_w[i+1]),
			.dn_rem_s (rem_s_w[i+1]),
			.dn_q_h   (q_h_w[i+1]),
			.dn_q_s   (q_s_w[i+1]),
			.dn_side  (side_w[i+1])
		);
	end

	rhc_finish #(
		.HUE_FRAC_BITS(HUE_FRAC_BITS),
		.NSTEP        (NSTEP)
	) u_finish (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (valid_w[NSTEP]),
		.up_ready (ready_w[NSTEP]),
		.up_q_h   (q_h_w[NSTEP]),
		.up_q_s   (q_s_w[NSTEP]),
		.up_side  (side_w[NSTEP]),
		.dn_valid (hsv_valid),
		.dn_ready (hsv_ready),
		.dn_hsv   (hsv)
	);

endmodule

// ----- design/rhc_checker.sv -----
// ----------------------------------------------------------------------------
// rhc_checker: port-level checks for the RGB to HSV converter
// Watches the top level ports; attached by the bind below.
// ----------------------------------------------------------------------------
module rhc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              pix_valid,
	input logic              pix_ready,
	input rhc_pkg::rhc_in_t  pix,
	input logic              hsv_valid,
	input logic              hsv_ready,
	input rhc_pkg::rhc_out_t hsv
);
	import rhc_pkg::*;

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && !hsv_ready |=> hsv_valid && $stable(hsv))
		else $error("stalled result item changed or dropped");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		(!hsv_valid || hsv_ready) |-> pix_ready)
		else $error("pixel refused while the result side can move");

	a_black_zero: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && hsv.val_out == '0 |-> hsv.sat_out == '0 && hsv.hue_out == '0)
		else $error("black pixel with nonzero hue or saturation");

	a_gray_hue: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && hsv.sat_out == '0 |-> hsv.hue_out == '0)
		else $error("unsaturated pixel with nonzero hue");

endmodule

bind rgb_to_hsv_converter_unit rhc_checker u_rhc_checker (.*);

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for the RGB to HSV converter
// Drives corner pixels, largest-channel ties, a full drain pause and a long
// random pixel stream under random idling on both sides. Every result is
// compared field by field against a local HSV model, in order of arrival.
// ----------------------------------------------------------------------------
module tb;

	import rhc_pkg::*;

	localparam int HUE_FRAC_BITS = 6;
	localparam int DRAIN_CYCLES  = 40;
	localparam int RANDOM_ITEMS  = 1000;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     pix_valid;
	logic     pix_ready;
	rhc_in_t  pix;
	logic     hsv_valid;
	logic     hsv_ready;
	rhc_out_t hsv;

	rhc_out_t hsv_expected_q[$];
	rhc_in_t  pix_sent_q[$];
	int       sent_cnt    = 0;
	int       checked_cnt = 0;
	int       err_cnt     = 0;
	bit       steady      = 1'b0;

	rgb_to_hsv_converter_unit #(
		.HUE_FRAC_BITS(HUE_FRAC_BITS)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.hsv_valid (hsv_valid),
		.hsv_ready (hsv_ready),
		.hsv       (hsv)
	);

	always #2 clk = ~clk;

	function automatic rhc_out_t hsv_of(input rhc_in_t p);
		int r, g, b, hi, lo, delta, hue, sat, sixty;
		rhc_out_t res;
		r     = int'(p.red_in);
		g     = int'(p.green_in);
		b     = int'(p.blue_in);
		hi    = r;
		lo    = r;
		hue   = 0;
		sat   = 0;
		sixty = 60 << HUE_FRAC_BITS;
		if (g > hi) hi = g;
		if (b > hi) hi = b;
		if (g < lo) lo = g;
		if (b < lo) lo = b;
		delta = hi - lo;
		if (delta != 0) begin
			if (hi == r)
				hue = (sixty * (g - b)) / delta;
			else if (hi == g)
				hue = (sixty * (b - r)) / delta + (120 << HUE_FRAC_BITS);
			else
				hue = (sixty * (r - g)) / delta + (240 << HUE_FRAC_BITS);
			if (hue < 0)
				hue += 360 << HUE_FRAC_BITS;
		end
		if (hi != 0)
			sat = (255 * delta) / hi;
		res.hue_out = hue[HUE_W-1:0];
		res.sat_out = sat[CHAN_W-1:0];
		res.val_out = hi[CHAN_W-1:0];
		return res;
	endfunction

	function automatic int idle_draw();
		if (steady)
			return 0;
		return $urandom_range(0, 18);
	endfunction

	function automatic logic [7:0] clamp_byte(input int v);
		if (v < 0)
			return 8'd0;
		if (v > 255)
			return 8'd255;
		return v[7:0];
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		err_cnt++;
	endtask

	// send one pixel item; valid stays high after acceptance until the next call
	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		int gap;
		gap = idle_draw();
		@(negedge clk);
		if (gap > 0) begin
			pix_valid <= 1'b0;
			pix       <= '{red_in: 8'($urandom), green_in: 8'($urandom),
				blue_in: 8'($urandom)};
			repeat (gap) @(negedge clk);
		end
		pix_valid <= 1'b1;
		pix       <= '{red_in: r, green_in: g, blue_in: b};
		do @(posedge clk); while (!pix_ready);
		hsv_expected_q.push_back(hsv_of(pix));
		pix_sent_q.push_back(pix);
		sent_cnt++;
	endtask

	task automatic stop_pixels();
		@(negedge clk);
		pix_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (hsv_expected_q.size() != 0) @(posedge clk);
	endtask

	initial begin
		int w;
		hsv_ready = 1'b0;
		forever begin
			w = idle_draw();
			@(negedge clk);
			if (w > 0) begin
				hsv_ready <= 1'b0;
				repeat (w) @(negedge clk);
			end
			hsv_ready <= 1'b1;
			do @(posedge clk); while (!(arst_n && hsv_valid));
		end
	end

	always @(posedge clk) begin
		rhc_out_t exp_hsv;
		rhc_in_t  src;
		if (arst_n && hsv_valid && hsv_ready) begin
			if (hsv_expected_q.size() == 0) begin
				report_mismatch($sformatf("result %0d/%0d/%0d with none pending",
					hsv.hue_out, hsv.sat_out, hsv.val_out));
			end else begin
				exp_hsv = hsv_expected_q.pop_front();
				src     = pix_sent_q.pop_front();
				checked_cnt++;
				if (hsv.hue_out !== exp_hsv.hue_out)
					report_mismatch($sformatf("rgb %0d,%0d,%0d hue %0d, want %0d",
						src.red_in, src.green_in, src.blue_in, hsv.hue_out, exp_hsv.hue_out));
				if (hsv.sat_out !== exp_hsv.sat_out)
					report_mismatch($sformatf("rgb %0d,%0d,%0d sat %0d, want %0d",
						src.red_in, src.green_in, src.blue_in, hsv.sat_out, exp_hsv.sat_out));
				if (hsv.val_out !== exp_hsv.val_out)
					report_mismatch($sformatf("rgb %0d,%0d,%0d val %0d, want %0d",
						src.red_in, src.green_in, src.blue_in, hsv.val_out, exp_hsv.val_out));
			end
		end
	end

	task automatic test_corner_pixels();
		send_pixel(8'd0,   8'd0,   8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd1,   8'd1,   8'd1);
		send_pixel(8'd255, 8'd0,   8'd0);
		send_pixel(8'd0,   8'd255, 8'd0);
		send_pixel(8'd0,   8'd0,   8'd255);
		send_pixel(8'd1,   8'd0,   8'd0);
		send_pixel(8'd0,   8'd0,   8'd1);
		send_pixel(8'd255, 8'd0,   8'd1);
		send_pixel(8'd255, 8'd1,   8'd0);
		send_pixel(8'd255, 8'd254, 8'd0);
		send_pixel(8'd170, 8'd85,  8'd255);
	endtask

	task automatic test_sector_ties();
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0,   8'd255, 8'd255);
		send_pixel(8'd255, 8'd0,   8'd255);
		send_pixel(8'd200, 8'd200, 8'd10);
		send_pixel(8'd10,  8'd200, 8'd200);
		send_pixel(8'd200, 8'd10,  8'd200);
		send_pixel(8'd254, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd254, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd254);
	endtask

	// send two bursts of eight pixels, holding the sender after each until every pending result has come back
	task automatic test_drain_pause();
		repeat (2) begin
			repeat (8) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
			stop_pixels();
			wait_drained();
			steady = ~steady;
		end
		steady = 1'b0;
	endtask

	task automatic test_random_pixels();
		int kind, m, o, base;
		logic [7:0] r, g, b;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 100 == 0)
				steady = ($urandom_range(0, 3) == 0);
			kind = $urandom_range(0, 9);
			case (kind)
				5: begin
					r = 8'($urandom);
					g = r;
					b = r;
				end
				6: begin
					m = $urandom_range(1, 255);
					o = $urandom_range(0, m);
					case ($urandom_range(0, 2))
						0:       begin r = 8'(m); g = 8'(m); b = 8'(o); end
						1:       begin r = 8'(o); g = 8'(m); b = 8'(m); end
						default: begin r = 8'(m); g = 8'(o); b = 8'(m); end
					endcase
				end
				7: begin
					base = $urandom_range(0, 255);
					r = clamp_byte(base + $urandom_range(0, 4) - 2);
					g = clamp_byte(base + $urandom_range(0, 4) - 2);
					b = clamp_byte(base + $urandom_range(0, 4) - 2);
				end
				8: begin
					r = ($urandom_range(0, 2) == 0) ? 8'd0 :
						(($urandom_range(0, 1) == 0) ? 8'd255 : 8'($urandom));
					g = ($urandom_range(0, 2) == 0) ? 8'd0 :
						(($urandom_range(0, 1) == 0) ? 8'd255 : 8'($urandom));
					b = ($urandom_range(0, 2) == 0) ? 8'd0 :
						(($urandom_range(0, 1) == 0) ? 8'd255 : 8'($urandom));
				end
				9: begin
					base = $urandom_range(1, 255);
					r = 8'(base);
					g = 8'(base);
					b = 8'(base);
					case ($urandom_range(0, 2))
						0:       r = 8'(base - 1);
						1:       g = 8'(base - 1);
						default: b = 8'(base - 1);
					endcase
				end
				default: begin
					r = 8'($urandom);
					g = 8'($urandom);
					b = 8'($urandom);
				end
			endcase
			send_pixel(r, g, b);
		end
		steady = 1'b0;
	endtask

	initial begin
		arst_n    = 1'b0;
		pix_valid = 1'b0;
		pix       = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_corner_pixels();
		test_sector_ties();
		test_drain_pause();
		test_random_pixels();
		stop_pixels();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d pixels: corners, gray, channel ties, near-gray and random",
			sent_cnt);
		$display("Checked %0d results with random stalls on both sides", checked_cnt);
		if (err_cnt == 0 && hsv_expected_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			if (hsv_expected_q.size() != 0)
				report_mismatch($sformatf("%0d results never arrived", hsv_expected_q.size()));
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Timed out with %0d results pending", hsv_expected_q.size());
		$display("Mismatches found");
		$finish;
	end

endmodule
